// ===== src/fpn3_pkg.sv =====
// Shared types and constants for the fractal 3D gradient noise block.
`timescale 1ns / 1ps
package fpn3_pkg;

  // Operand and product of the shared multiplier.
  typedef logic signed [32:0] mul_op_t;
  typedef logic signed [65:0] mul_prod_t;

  // Configuration register indexes.
  localparam logic [2:0] CFG_OCTAVES   = 3'd0;
  localparam logic [2:0] CFG_FREQUENCY = 3'd1;
  localparam logic [2:0] CFG_AMPLITUDE = 3'd2;
  localparam logic [2:0] CFG_LACUNAR   = 3'd3;
  localparam logic [2:0] CFG_PERSIST   = 3'd4;

  // Request kinds on the input channel.
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_EVAL = 1'b1;

  // Register reset values.
  localparam logic [4:0]  RST_OCTAVES   = 5'd1;
  localparam logic [31:0] RST_FREQUENCY = 32'd65536;
  localparam logic [15:0] RST_AMPLITUDE = 16'd4096;
  localparam logic [15:0] RST_LACUNAR   = 16'd8192;
  localparam logic [15:0] RST_PERSIST   = 16'd32768;

  // Fade polynomial constants in Q16.16 / Q32.32.
  localparam mul_op_t   FADE_K15 = 33'sd983040;
  localparam mul_prod_t FADE_K10 = 66'sd42949672960;

  localparam logic signed [17:0] Q16_ONE = 18'sd65536;

  localparam logic signed [17:0] RES_MAX = 18'sd131071;
  localparam logic signed [17:0] RES_MIN = -18'sd131072;

endpackage

// ===== src/fpn3_mul.sv =====
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps
module fpn3_mul (
  input  logic             clk,
  input  fpn3_pkg::mul_op_t   op_a,
  input  fpn3_pkg::mul_op_t   op_b,
  output fpn3_pkg::mul_prod_t prod
);
  import fpn3_pkg::*;

  mul_prod_t prod_r;

  always_ff @(posedge clk) begin
    prod_r <= mul_prod_t'(op_a) * mul_prod_t'(op_b);
  end

  assign prod = prod_r;

endmodule

// ===== src/fractal_perlin_noise_3d_top.sv =====
// Top level of the fractal 3D improved gradient noise evaluator.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------------------
//  in_     | slave     | in_tvalid/in_tready | tuser: action; tdata: index,value,x,y,z
//  out_    | master    | out_tvalid/tready   | tdata: noise_value (Q1.16)
//  cfg_    | slave     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// A load request writes one permutation byte. An evaluate request runs each octave
// in turn and then a final division; the single shared multiplier and the single
// read port of the permutation memory pace the work of each octave.
// Reset (rst_n, synchronous, active low) clears the control state; the
// permutation memory is not cleared and must be loaded before use.
// A finished result waits in the output register while new requests are taken;
// only the next evaluate result stalls until the output register is free.
`timescale 1ns / 1ps
module fractal_perlin_noise_3d_top #(
  parameter int TABLE_SIZE  = 256,
  parameter int MAX_OCTAVES = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [0:0]   in_tuser,   // [0] action
  input  logic [111:0] in_tdata,   // [7:0] table_index, [15:8] table_value,
                                   // [47:16] coord_x, [79:48] coord_y, [111:80] coord_z
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [23:0]  out_tdata,  // [17:0] noise_value, rest zero
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import fpn3_pkg::*;

  localparam int TAW = $clog2(TABLE_SIZE);
  localparam int OCW = $clog2(MAX_OCTAVES + 1);
  localparam int CW  = (OCW > 5) ? OCW : 5;
  localparam int TW  = 36 + OCW;          // weighted sum width
  localparam int SW  = 16 + OCW;          // amplitude sum width
  localparam int DCW = $clog2(TW + 1);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SCALE = 4'd1;
  localparam logic [3:0] ST_FADE  = 4'd2;
  localparam logic [3:0] ST_HASH  = 4'd3;
  localparam logic [3:0] ST_LERP  = 4'd4;
  localparam logic [3:0] ST_ACC   = 4'd5;
  localparam logic [3:0] ST_NEXT  = 4'd6;
  localparam logic [3:0] ST_DIVI  = 4'd7;
  localparam logic [3:0] ST_DIV   = 4'd8;
  localparam logic [3:0] ST_FIN   = 4'd9;

  // Improved noise gradient: one of twelve cube edge directions from four hash bits.
  function automatic logic signed [18:0] grad_f(input logic [3:0] h,
                                                input logic signed [17:0] x,
                                                input logic signed [17:0] y,
                                                input logic signed [17:0] z);
    logic signed [18:0] u, v, r;
    u = (h < 4'd8) ? 19'(x) : 19'(y);
    v = (h < 4'd4) ? 19'(y) : ((h == 4'd12 || h == 4'd14) ? 19'(x) : 19'(z));
    r = h[0] ? -u : u;
    r = h[1] ? r - v : r + v;
    return r;
  endfunction

  // Configuration registers.
  logic [4:0]  oct_cfg_r;
  logic [31:0] freq_cfg_r;
  logic [15:0] amp_cfg_r, lac_cfg_r, pers_cfg_r;

  // Permutation memory.
  logic [7:0]     perm_mem [TABLE_SIZE];
  logic [TAW-1:0] rd_addr;
  logic [7:0]     rdata_r;

  // Sequencer and datapath registers.
  logic [3:0]  state_r, state_nxt;
  logic [3:0]  step_r, step_nxt;
  logic        ph_r, ph_nxt;
  logic [OCW-1:0] oct_r, oct_nxt, nlim_r, nlim_nxt;
  logic signed [31:0] cx_r, cx_nxt, cy_r, cy_nxt, cz_r, cz_nxt;
  logic [31:0] freq_r, freq_nxt;
  logic [15:0] amp_r, amp_nxt;
  logic [7:0]  cell_r [3];
  logic [7:0]  cell_nxt [3];
  logic [15:0] frac_r [3];
  logic [15:0] frac_nxt [3];
  logic [16:0] fade_r [3];
  logic [16:0] fade_nxt [3];
  logic [20:0] tmp_r, tmp_nxt;
  logic [15:0] t3_r, t3_nxt;
  logic [7:0]  ax_r, ax_nxt, bx_r, bx_nxt, ay_r, ay_nxt, az_r, az_nxt;
  logic [7:0]  by_r, by_nxt, bz_r, bz_nxt;
  logic [3:0]  h_r [8];
  logic [3:0]  h_nxt [8];
  logic signed [19:0] la_r, la_nxt;
  logic signed [19:0] n0_r, n0_nxt, n1_r, n1_nxt, n2_r, n2_nxt, n3_r, n3_nxt;
  logic signed [19:0] m0_r, m0_nxt, m1_r, m1_nxt, v_r, v_nxt;
  logic signed [TW-1:0] total_r, total_nxt;
  logic [SW-1:0] sum_r, sum_nxt, rem_r, rem_nxt;
  logic [TW-1:0] quo_r, quo_nxt;
  logic          neg_r, neg_nxt;
  logic [DCW-1:0] dcnt_r, dcnt_nxt;
  logic          out_tvalid_r, out_tvalid_nxt;
  logic signed [17:0] out_data_r, out_data_nxt;

  mul_op_t   mul_a, mul_b;
  mul_prod_t prod;

  logic in_acc;
  logic [1:0] fax;
  logic [2:0] lk;
  logic [15:0] ft;
  logic signed [17:0] gx0, gx1, gy, gz;
  logic signed [19:0] la_sel, lb_sel;
  logic signed [20:0] ldiff;
  logic [16:0] lt_sel;
  logic [SW:0] trial;
  logic [CW-1:0] oct_req;
  logic signed [19:0] lres;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {6'b0, out_data_r};

  // Configuration writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oct_cfg_r  <= RST_OCTAVES;
      freq_cfg_r <= RST_FREQUENCY;
      amp_cfg_r  <= RST_AMPLITUDE;
      lac_cfg_r  <= RST_LACUNAR;
      pers_cfg_r <= RST_PERSIST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_OCTAVES:   oct_cfg_r  <= cfg_data[4:0];
        CFG_FREQUENCY: freq_cfg_r <= cfg_data;
        CFG_AMPLITUDE: amp_cfg_r  <= cfg_data[15:0];
        CFG_LACUNAR:   lac_cfg_r  <= cfg_data[15:0];
        CFG_PERSIST:   pers_cfg_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Permutation memory: one write port for load requests, one registered read port.
  always_ff @(posedge clk) begin
    if (in_acc && in_tuser[0] == ACT_LOAD) begin
      perm_mem[in_tdata[TAW-1:0]] <= in_tdata[15:8];
    end
    rdata_r <= perm_mem[rd_addr];
  end

  fpn3_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  // Step decoding shared by the operand mux and the sequencer.
  assign fax = step_r[3:2];
  assign ft  = frac_r[fax];
  assign lk  = step_r[2:0];
  assign gx0 = 18'(frac_r[0]);
  assign gx1 = 18'(frac_r[0]) - Q16_ONE;
  assign gy  = lk[0] ? 18'(frac_r[1]) - Q16_ONE : 18'(frac_r[1]);
  assign gz  = lk[1] ? 18'(frac_r[2]) - Q16_ONE : 18'(frac_r[2]);

  always_comb begin
    la_sel = 20'(grad_f(h_r[0], gx0, gy, gz));
    lb_sel = 20'(grad_f(h_r[1], gx1, gy, gz));
    lt_sel = fade_r[0];
    case (lk)
      3'd4: begin la_sel = n0_r; lb_sel = n1_r; lt_sel = fade_r[1]; end
      3'd5: begin la_sel = n2_r; lb_sel = n3_r; lt_sel = fade_r[1]; end
      3'd6: begin la_sel = m0_r; lb_sel = m1_r; lt_sel = fade_r[2]; end
      default: ;
    endcase
  end
  assign ldiff = 21'(lb_sel) - 21'(la_sel);
  assign lres  = la_r + 20'(prod >>> 16);
  assign trial = {rem_r, quo_r[TW-1]};
  assign oct_req = CW'(oct_cfg_r);

  // Operands of the shared multiplier and the memory read address.
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    rd_addr = '0;
    case (state_r)
      ST_SCALE: begin
        case (step_r[1:0])
          2'd0:    mul_a = 33'(cx_r);
          2'd1:    mul_a = 33'(cy_r);
          default: mul_a = 33'(cz_r);
        endcase
        mul_b = {1'b0, freq_r};
      end
      ST_FADE: begin
        case (step_r[1:0])
          2'd0: begin mul_a = 33'(ft); mul_b = 33'(ft); end
          2'd1: begin mul_a = 33'(tmp_r[15:0]); mul_b = 33'(ft); end
          2'd2: begin
            mul_a = 33'(ft);
            mul_b = (33'(ft) <<< 2) + (33'(ft) <<< 1) - FADE_K15;
          end
          default: begin mul_a = 33'(t3_r); mul_b = 33'(tmp_r); end
        endcase
      end
      ST_HASH: begin
        case (step_r)
          4'd0:    rd_addr = cell_r[0];
          4'd1:    rd_addr = cell_r[0] + 8'd1;
          4'd2:    rd_addr = ax_r;
          4'd3:    rd_addr = ax_r + 8'd1;
          4'd4:    rd_addr = bx_r;
          4'd5:    rd_addr = bx_r + 8'd1;
          4'd6:    rd_addr = ay_r;
          4'd7:    rd_addr = by_r;
          4'd8:    rd_addr = az_r;
          4'd9:    rd_addr = bz_r;
          4'd10:   rd_addr = ay_r + 8'd1;
          4'd11:   rd_addr = by_r + 8'd1;
          4'd12:   rd_addr = az_r + 8'd1;
          default: rd_addr = bz_r + 8'd1;
        endcase
      end
      ST_LERP: begin
        mul_a = 33'(lt_sel);
        mul_b = 33'(ldiff);
      end
      ST_ACC: begin
        mul_a = 33'(v_r);
        mul_b = 33'(amp_r);
      end
      ST_NEXT: begin
        if (step_r[0]) begin
          mul_a = 33'(amp_r);
          mul_b = 33'(pers_cfg_r);
        end else begin
          mul_a = 33'(freq_r);
          mul_b = 33'(lac_cfg_r);
        end
      end
      default: ;
    endcase
  end

  // Sequencer: before division, even phase issues an operation, odd takes its result.
  always_comb begin
    state_nxt = state_r;  step_nxt = step_r;  ph_nxt = ph_r;
    oct_nxt = oct_r;  nlim_nxt = nlim_r;
    cx_nxt = cx_r;  cy_nxt = cy_r;  cz_nxt = cz_r;
    freq_nxt = freq_r;  amp_nxt = amp_r;
    cell_nxt = cell_r;  frac_nxt = frac_r;  fade_nxt = fade_r;
    tmp_nxt = tmp_r;  t3_nxt = t3_r;
    ax_nxt = ax_r;  bx_nxt = bx_r;  ay_nxt = ay_r;  az_nxt = az_r;
    by_nxt = by_r;  bz_nxt = bz_r;  h_nxt = h_r;  la_nxt = la_r;
    n0_nxt = n0_r;  n1_nxt = n1_r;  n2_nxt = n2_r;  n3_nxt = n3_r;
    m0_nxt = m0_r;  m1_nxt = m1_r;  v_nxt = v_r;
    total_nxt = total_r;  sum_nxt = sum_r;  rem_nxt = rem_r;  quo_nxt = quo_r;
    neg_nxt = neg_r;  dcnt_nxt = dcnt_r;
    out_tvalid_nxt = out_tvalid_r;  out_data_nxt = out_data_r;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_tuser[0] == ACT_EVAL) begin
          cx_nxt    = in_tdata[47:16];
          cy_nxt    = in_tdata[79:48];
          cz_nxt    = in_tdata[111:80];
          freq_nxt  = freq_cfg_r;
          amp_nxt   = amp_cfg_r;
          total_nxt = '0;
          sum_nxt   = '0;
          oct_nxt   = '0;
          nlim_nxt  = (oct_req > CW'(MAX_OCTAVES)) ? OCW'(MAX_OCTAVES)
                                                   : OCW'(oct_req);
          step_nxt  = '0;
          ph_nxt    = 1'b0;
          state_nxt = (oct_cfg_r == 5'd0) ? ST_DIVI : ST_SCALE;
        end
      end
      ST_SCALE: begin
        ph_nxt = ~ph_r;
        if (ph_r) begin
          cell_nxt[step_r[1:0]] = prod[39:32];
          frac_nxt[step_r[1:0]] = prod[31:16];
          if (step_r == 4'd2) begin
            step_nxt  = '0;
            state_nxt = ST_FADE;
          end else begin
            step_nxt = step_r + 4'd1;
          end
        end
      end
      ST_FADE: begin
        ph_nxt = ~ph_r;
        if (ph_r) begin
          case (step_r[1:0])
            2'd0:    tmp_nxt = 21'(prod[31:16]);
            2'd1:    t3_nxt  = prod[31:16];
            2'd2:    tmp_nxt = 21'((prod + FADE_K10) >>> 16);
            default: fade_nxt[fax] = prod[32:16];
          endcase
          if (step_r == 4'd11) begin
            step_nxt  = '0;
            state_nxt = ST_HASH;
          end else begin
            step_nxt = step_r + 4'd1;
          end
        end
      end
      ST_HASH: begin
        ph_nxt = ~ph_r;
        if (ph_r) begin
          case (step_r)
            4'd0: ax_nxt = rdata_r + cell_r[1];
            4'd1: bx_nxt = rdata_r + cell_r[1];
            4'd2: ay_nxt = rdata_r + cell_r[2];
            4'd3: az_nxt = rdata_r + cell_r[2];
            4'd4: by_nxt = rdata_r + cell_r[2];
            4'd5: bz_nxt = rdata_r + cell_r[2];
            default: begin
              for (int i = 0; i < 7; i++) h_nxt[i] = h_r[i+1];
              h_nxt[7] = rdata_r[3:0];
            end
          endcase
          if (step_r == 4'd13) begin
            step_nxt  = '0;
            state_nxt = ST_LERP;
          end else begin
            step_nxt = step_r + 4'd1;
          end
        end
      end
      ST_LERP: begin
        ph_nxt = ~ph_r;
        if (!ph_r) begin
          la_nxt = la_sel;
        end else begin
          case (lk)
            3'd0: n0_nxt = lres;
            3'd1: n1_nxt = lres;
            3'd2: n2_nxt = lres;
            3'd3: n3_nxt = lres;
            3'd4: m0_nxt = lres;
            3'd5: m1_nxt = lres;
            default: v_nxt = lres;
          endcase
          if (lk < 3'd4) begin
            for (int i = 0; i < 6; i++) h_nxt[i] = h_r[i+2];
          end
          if (lk == 3'd6) begin
            step_nxt  = '0;
            state_nxt = ST_ACC;
          end else begin
            step_nxt = step_r + 4'd1;
          end
        end
      end
      ST_ACC: begin
        ph_nxt = ~ph_r;
        if (ph_r) begin
          total_nxt = total_r + TW'($signed(prod[35:0]));
          sum_nxt   = sum_r + SW'(amp_r);
          state_nxt = ST_NEXT;
        end
      end
      ST_NEXT: begin
        ph_nxt = ~ph_r;
        if (ph_r) begin
          if (step_r[0]) begin
            amp_nxt = prod[31:16];
            oct_nxt = oct_r + OCW'(1);
            step_nxt = '0;
            state_nxt = (oct_r + OCW'(1) == nlim_r) ? ST_DIVI : ST_SCALE;
          end else begin
            freq_nxt = (prod[47:44] != 4'd0) ? 32'hFFFF_FFFF : prod[43:12];
            step_nxt = 4'd1;
          end
        end
      end
      ST_DIVI: begin
        // Divide magnitudes; the sign is put back at the end.
        neg_nxt  = total_r[TW-1];
        quo_nxt  = total_r[TW-1] ? TW'(-total_r) : TW'(total_r);
        rem_nxt  = '0;
        dcnt_nxt = '0;
        if (sum_r == '0) begin
          quo_nxt   = '0;
          neg_nxt   = 1'b0;
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (trial >= {1'b0, sum_r}) begin
          rem_nxt = SW'(trial - {1'b0, sum_r});
          quo_nxt = {quo_r[TW-2:0], 1'b1};
        end else begin
          rem_nxt = trial[SW-1:0];
          quo_nxt = {quo_r[TW-2:0], 1'b0};
        end
        dcnt_nxt = dcnt_r + DCW'(1);
        if (dcnt_r == DCW'(TW - 1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_tvalid_r || out_tready) begin
          if (!neg_r) begin
            out_data_nxt = (quo_r > TW'(RES_MAX)) ? RES_MAX : 18'(quo_r);
          end else begin
            out_data_nxt = (quo_r > TW'(131072)) ? RES_MIN : -18'(quo_r);
          end
          out_tvalid_nxt = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      step_r       <= '0;
      ph_r         <= 1'b0;
      oct_r        <= '0;
      nlim_r       <= '0;
      dcnt_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      step_r       <= step_nxt;
      ph_r         <= ph_nxt;
      oct_r        <= oct_nxt;
      nlim_r       <= nlim_nxt;
      dcnt_r       <= dcnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cx_r <= cx_nxt;  cy_r <= cy_nxt;  cz_r <= cz_nxt;
    freq_r <= freq_nxt;  amp_r <= amp_nxt;
    cell_r <= cell_nxt;  frac_r <= frac_nxt;  fade_r <= fade_nxt;
    tmp_r <= tmp_nxt;  t3_r <= t3_nxt;
    ax_r <= ax_nxt;  bx_r <= bx_nxt;  ay_r <= ay_nxt;  az_r <= az_nxt;
    by_r <= by_nxt;  bz_r <= bz_nxt;  h_r <= h_nxt;  la_r <= la_nxt;
    n0_r <= n0_nxt;  n1_r <= n1_nxt;  n2_r <= n2_nxt;  n3_r <= n3_nxt;
    m0_r <= m0_nxt;  m1_r <= m1_nxt;  v_r <= v_nxt;
    total_r <= total_nxt;  sum_r <= sum_nxt;  rem_r <= rem_nxt;  quo_r <= quo_nxt;
    neg_r <= neg_nxt;  out_data_r <= out_data_nxt;
  end

  // The divider only runs with a nonzero divisor, and its remainder stays below it.
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> sum_r != '0)
    else $error("divider started with a zero amplitude sum");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> rem_r < sum_r)
    else $error("division remainder out of range");

  // The octave loop never runs past its limit.
  a_oct_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_NEXT && ph_r) |-> oct_r < nlim_r)
    else $error("octave counter past its limit");

  // A result is held until the output side takes it.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && out_tvalid_r && !out_tready) |=> state_r == ST_FIN)
    else $error("result left the divider while output was full");

endmodule

// ===== tb/fpn3_checker.sv =====
// Scoreboard for the fractal noise block: predicts noise values and compares results.
`timescale 1ns / 1ps
module fpn3_checker
  import fpn3_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [0:0]   in_tuser,
  input  logic [111:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [23:0]  out_tdata,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  output int           error_count,
  output int           pending_noise
);

  logic [7:0]  perm_mem [256];
  logic [4:0]  octaves_reg;
  logic [31:0] freq_reg;
  logic [15:0] amp_reg;
  logic [15:0] lacun_reg;
  logic [15:0] persist_reg;
  logic signed [17:0] noise_q [$];

  function automatic longint fade_q16(longint t);
    longint inner, t3;
    inner = 64'sd42949672960 + t * (6 * t - 64'sd983040);
    t3 = (((t * t) >>> 16) * t) >>> 16;
    return (t3 * (inner >>> 16)) >>> 16;
  endfunction

  function automatic longint lerp_q16(longint t, longint a, longint b);
    return a + ((t * (b - a)) >>> 16);
  endfunction

  function automatic longint grad_dot(int unsigned hash, longint x, longint y, longint z);
    logic [3:0] h;
    longint u, v, r;
    h = hash[3:0];
    u = (h < 8) ? x : y;
    v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
    r = h[0] ? -u : u;
    r += h[1] ? -v : v;
    return r;
  endfunction

  function automatic int unsigned perm_at(int unsigned i);
    return int'(perm_mem[i[7:0]]);
  endfunction

  // One octave of gradient noise at lattice cell (cx,cy,cz) with Q0.16 fractions.
  function automatic longint octave_noise(int unsigned cx, int unsigned cy, int unsigned cz,
                                          longint x, longint y, longint z);
    longint ux, uy, uz, n0, n1, n2, n3;
    int unsigned ax, ay, az, bx, by, bz;
    ux = fade_q16(x);
    uy = fade_q16(y);
    uz = fade_q16(z);
    ax = perm_at(cx) + cy;
    ay = perm_at(ax) + cz;
    az = perm_at(ax + 1) + cz;
    bx = perm_at(cx + 1) + cy;
    by = perm_at(bx) + cz;
    bz = perm_at(bx + 1) + cz;
    n0 = lerp_q16(ux, grad_dot(perm_at(ay), x, y, z),
                  grad_dot(perm_at(by), x - 65536, y, z));
    n1 = lerp_q16(ux, grad_dot(perm_at(az), x, y - 65536, z),
                  grad_dot(perm_at(bz), x - 65536, y - 65536, z));
    n2 = lerp_q16(ux, grad_dot(perm_at(ay + 1), x, y, z - 65536),
                  grad_dot(perm_at(by + 1), x - 65536, y, z - 65536));
    n3 = lerp_q16(ux, grad_dot(perm_at(az + 1), x, y - 65536, z - 65536),
                  grad_dot(perm_at(bz + 1), x - 65536, y - 65536, z - 65536));
    return lerp_q16(uz, lerp_q16(uy, n0, n1), lerp_q16(uy, n2, n3));
  endfunction

  function automatic logic signed [17:0] fractal_noise(logic [31:0] cx, logic [31:0] cy,
                                                       logic [31:0] cz);
    logic [63:0] px, py, pz, sx, sy, sz, frq, amp;
    longint total, amp_sum, res;
    int n;
    px = {{32{cx[31]}}, cx};
    py = {{32{cy[31]}}, cy};
    pz = {{32{cz[31]}}, cz};
    frq = {32'd0, freq_reg};
    amp = {48'd0, amp_reg};
    n = (octaves_reg > 16) ? 16 : int'(octaves_reg);
    total = 0;
    amp_sum = 0;
    res = 0;
    for (int i = 0; i < n; i++) begin
      sx = px * frq;
      sy = py * frq;
      sz = pz * frq;
      total += octave_noise(sx[39:32], sy[39:32], sz[39:32],
                            longint'({48'd0, sx[31:16]}), longint'({48'd0, sy[31:16]}),
                            longint'({48'd0, sz[31:16]})) * longint'(amp);
      amp_sum += longint'(amp);
      frq = (frq * {48'd0, lacun_reg}) >> 12;
      if (frq > 64'hFFFF_FFFF) frq = 64'hFFFF_FFFF;
      amp = (amp * {48'd0, persist_reg}) >> 16;
    end
    if (amp_sum != 0) res = total / amp_sum;
    if (res > 131071) res = 131071;
    if (res < -131072) res = -131072;
    return res[17:0];
  endfunction

  always @(posedge clk) begin
    logic signed [17:0] want;
    if (!rst_n) begin
      octaves_reg <= RST_OCTAVES;
      freq_reg    <= RST_FREQUENCY;
      amp_reg     <= RST_AMPLITUDE;
      lacun_reg   <= RST_LACUNAR;
      persist_reg <= RST_PERSIST;
      noise_q.delete();
      error_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_OCTAVES:   octaves_reg <= cfg_data[4:0];
          CFG_FREQUENCY: freq_reg    <= cfg_data;
          CFG_AMPLITUDE: amp_reg     <= cfg_data[15:0];
          CFG_LACUNAR:   lacun_reg   <= cfg_data[15:0];
          CFG_PERSIST:   persist_reg <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser[0] == ACT_LOAD) perm_mem[in_tdata[7:0]] <= in_tdata[15:8];
        else noise_q.push_back(fractal_noise(in_tdata[47:16], in_tdata[79:48],
                                             in_tdata[111:80]));
      end
      if (out_tvalid && out_tready) begin
        if (noise_q.size() == 0) begin
          $display("%0t: unexpected noise_value result: expected none, got %0d",
                   $time, $signed(out_tdata[17:0]));
          error_count <= error_count + 1;
        end else begin
          want = noise_q.pop_front();
          if (out_tdata[17:0] !== want) begin
            $display("%0t: noise_value mismatch: expected %0d, got %0d",
                     $time, want, $signed(out_tdata[17:0]));
            error_count <= error_count + 1;
          end
        end
      end
    end
    pending_noise = noise_q.size();
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the fractal noise testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
  import fpn3_pkg::*;

  localparam int CYCLE_LIMIT = 8000000;
  localparam int LONG_HOLD   = 4000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [0:0]   in_tuser = ACT_LOAD;
  logic [111:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [23:0]  out_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = CFG_OCTAVES;
  logic [31:0]  cfg_data = '0;

  int error_count;
  int pending_noise;
  int cycle_count = 0;
  int burst_left = 0;
  bit hold_request = 1'b0;

  // Clock with a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  fractal_perlin_noise_3d_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  fpn3_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .error_count(error_count), .pending_noise(pending_noise)
  );

  // Watchdog: a run that hangs is a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** fractal_perlin_noise_3d_top: FAILED **");
      $finish;
    end
  end

  // The result side stalls in segments: always ready, mostly ready or mostly
  // stalled. Once asked, it holds off for a long stretch so that the block
  // fills up and has to push back on new requests.
  initial begin
    int seg_mode, seg_len;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      seg_mode = $urandom_range(0, 2);
      seg_len = $urandom_range(10, 200);
      repeat (seg_len) begin
        @(posedge clk);
        case (seg_mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 3) != 0);
          default: out_tready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // Offers one request until the edge where it is taken. At the end of a burst it
  // mostly drops valid for a pause; else valid stays high into the next request.
  task automatic send_request(logic act, logic [111:0] payload);
    in_tuser  <= act;
    in_tdata  <= payload;
    in_tvalid <= 1'b1;
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(0, 24);
      if ($urandom_range(0, 3) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic load_entry(logic [7:0] idx, logic [7:0] val);
    send_request(ACT_LOAD, {96'd0, val, idx});
  endtask

  task automatic eval_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    send_request(ACT_EVAL, {z, y, x, 16'd0});
  endtask

  // Returns once every predicted result has been delivered.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending_noise != 0);
    @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
  endtask

  // Registers change only with the block idle. A trailing load produces no
  // result, so a short pause lets any remaining work settle first.
  task automatic set_config(logic [4:0] oct, logic [31:0] frq, logic [15:0] amp,
                            logic [15:0] lac, logic [15:0] per);
    drain_results();
    repeat (64) @(posedge clk);
    write_reg(CFG_OCTAVES, {27'd0, oct});
    write_reg(CFG_FREQUENCY, frq);
    write_reg(CFG_AMPLITUDE, {16'd0, amp});
    write_reg(CFG_LACUNAR, {16'd0, lac});
    write_reg(CFG_PERSIST, {16'd0, per});
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
      2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
      default: return 32'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
    endcase
  endfunction

  function automatic logic [31:0] rand_freq();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 32'h0004_0000);
      2: return 32'h0001_0000;
      default: return $urandom_range(32'h0000_1000, 32'h0000_FFFF);
    endcase
  endfunction

  initial begin
    logic [7:0] shuffled [256];
    logic [7:0] swap_byte;
    int pick, phase_items;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill the whole permutation table first so that no evaluate request
    // ever reads an entry that was never loaded. Entry 0 gets 255 and
    // entry 255 gets 0 to cover both index and value extremes.
    for (int i = 0; i < 256; i++) shuffled[i] = 8'(i);
    for (int i = 255; i > 0; i--) begin
      pick = $urandom_range(0, i);
      swap_byte = shuffled[i];
      shuffled[i] = shuffled[pick];
      shuffled[pick] = swap_byte;
    end
    load_entry(8'd0, 8'd255);
    load_entry(8'd255, 8'd0);
    for (int i = 1; i < 255; i++) load_entry(8'(i), shuffled[i]);

    // Directed points with the reset configuration: origin, the coordinate
    // extremes, all ones, fractions just below a lattice boundary and halves.
    eval_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    eval_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    eval_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    eval_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    eval_point(32'h0000_FFFF, 32'h0001_8000, 32'hFFFF_8000);
    eval_point(32'h7FFF_8000, 32'h8000_8000, 32'h0000_4000);
    eval_point(32'h0003_0000, 32'h0005_0000, 32'hFFFE_0000);

    // Largest settings: sixteen octaves, saturating frequency, full weights.
    set_config(5'd16, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    eval_point(32'h0001_2345, 32'hFFFE_ABCD, 32'h7FFF_FFFF);
    eval_point(32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF);
    // Octave count above the maximum is clipped to sixteen octaves.
    set_config(5'd31, 32'h0000_8000, 16'h1000, 16'h2000, 16'h8000);
    eval_point(32'h0001_8000, 32'h0002_4000, 32'h0003_C000);
    // No octaves at all yields zero.
    set_config(5'd0, 32'h0001_0000, 16'h0001, 16'h0000, 16'h0000);
    eval_point(32'h0001_8000, 32'h0002_4000, 32'h0003_C000);
    // Smallest values: zero frequency, smallest weight, zero multipliers.
    set_config(5'd3, 32'h0000_0000, 16'h0001, 16'h0000, 16'h0000);
    eval_point(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F);
    eval_point(32'h0000_8000, 32'h0000_8000, 32'h0000_8000);

    // Random phases, each under its own configuration. Most use few octaves
    // to keep the run short; one phase goes deep with twelve octaves.
    for (int phase = 0; phase < 9; phase++) begin
      set_config((phase == 5) ? 5'd12 : 5'($urandom_range(1, 4)), rand_freq(),
                 16'($urandom_range(1, 65535)), 16'($urandom()), 16'($urandom()));
      phase_items = (phase == 5) ? 30 : 100;
      if (phase == 2) hold_request = 1'b1;
      for (int k = 0; k < phase_items; k++) begin
        // Once mid phase, stop offering until all results are back.
        if (phase == 4 && k == phase_items / 2) drain_results();
        if ($urandom_range(0, 9) < 3) load_entry(8'($urandom()), 8'($urandom()));
        else eval_point(rand_coord(), rand_coord(), rand_coord());
      end
    end

    drain_results();
    repeat (200) @(posedge clk);
    if (error_count == 0) begin
      $display("** fractal_perlin_noise_3d_top: PASSED **");
    end else begin
      $display("** fractal_perlin_noise_3d_top: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/fpn3_pkg.sv
src/fpn3_mul.sv
src/fractal_perlin_noise_3d_top.sv
tb/fpn3_checker.sv
tb/testbench.sv
